// File: hw/rtl/gclw_pkg.sv
// ----------------------------------------------------------------------------
// gclw_pkg: shared types and codes for the grid cell line walker
// Fixed port widths, axis mode codes and the result cell record.
// ----------------------------------------------------------------------------
package gclw_pkg;

    localparam int COORD_W   = 13;  // one input coordinate
    localparam int CELL_W    = 5;   // output column / row
    localparam int WALK_W    = 6;   // walk position register
    localparam int CNT_W     = 7;   // cells still to emit
    localparam int S_TDATA_W = 56;  // four coordinates, padded to bytes
    localparam int M_TDATA_W = 16;  // column and row, padded to bytes

    // axis mode codes
    localparam logic [1:0] MODE_GENERAL = 2'd0;
    localparam logic [1:0] MODE_VERT    = 2'd1;
    localparam logic [1:0] MODE_HORIZ   = 2'd2;

    typedef struct packed {
        logic                     last;
        logic signed [CELL_W-1:0] row;
        logic signed [CELL_W-1:0] col;
    } cell_t;

endpackage

// File: hw/rtl/gclw_fifo.sv
// ----------------------------------------------------------------------------
// gclw_fifo: two-entry command queue
// Decouples the segment setup front end from the cell walker.
// ----------------------------------------------------------------------------
module gclw_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + 2'd1;
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

// File: hw/rtl/gclw_front.sv
// ----------------------------------------------------------------------------
// gclw_front: segment setup
// Clamps the end points, derives extents, directions, cell count, axis mode
// and the initial error term, and pushes one walk command per segment.
// ----------------------------------------------------------------------------
module gclw_front #(
    parameter int GRID_CELLS = 32,
    parameter int FRAC_BITS  = 8,
    parameter int CMD_W      = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [4*gclw_pkg::COORD_W-1:0] s_coords,
    output logic                           q_push,
    output logic [CMD_W-1:0]               q_data,
    input  logic                           q_full
);

    import gclw_pkg::*;

    localparam int CW     = (FRAC_BITS + 6 > COORD_W) ? FRAC_BITS + 6 : COORD_W;
    localparam int EXT_W  = FRAC_BITS + 5;
    localparam int MUL_W  = FRAC_BITS + 1;
    localparam int PROD_W = MUL_W + EXT_W;
    localparam int ERR_W  = 2 * FRAC_BITS + 8;
    localparam logic signed [CW-1:0] HI_C = CW'((GRID_CELLS / 2) * (1 << FRAC_BITS) - 1);
    localparam logic signed [CW-1:0] LO_C = CW'(-(GRID_CELLS / 2) * (1 << FRAC_BITS));
    localparam logic [MUL_W-1:0]     ONE  = MUL_W'(1) << FRAC_BITS;

    function automatic logic signed [CW-1:0] clamp(input logic signed [COORD_W-1:0] v);
        logic signed [CW-1:0] w;
        w = CW'(v);
        if (w < LO_C) begin
            w = LO_C;
        end else if (w > HI_C) begin
            w = HI_C;
        end
        return w;
    endfunction

    // stage 1 combinational
    logic signed [CW-1:0]     x0, y0, x1, y1;
    logic signed [CW:0]       dxs, dys;
    logic                     xpos, ypos;
    logic [EXT_W-1:0]         ext_x_c, ext_y_c;
    logic [MUL_W-1:0]         mx_c, my_c;
    logic                     en;

    // stage 1 registers
    logic                     v1_reg;
    logic signed [CELL_W-1:0] fx0_reg, fx1_reg, fy0_reg, fy1_reg;
    logic [EXT_W-1:0]         ext_x1_reg, ext_y1_reg;
    logic [MUL_W-1:0]         mx_reg, my_reg;
    logic                     xneg1_reg, yneg1_reg;

    // stage 2 combinational
    logic [WALK_W-1:0]        dcol, drow;
    logic [CNT_W-1:0]         cells_c;
    logic [1:0]               mode_c;

    // stage 2 registers
    logic                     v2_reg;
    logic [PROD_W-1:0]        prod_x_reg, prod_y_reg;
    logic [WALK_W-1:0]        col_reg, row_reg;
    logic [CNT_W-1:0]         cells_reg;
    logic [1:0]               mode_reg;
    logic [EXT_W-1:0]         ext_x2_reg, ext_y2_reg;
    logic                     xneg2_reg, yneg2_reg;
    logic signed [ERR_W-1:0]  err_c;

    assign x0 = clamp(s_coords[COORD_W-1:0]);
    assign y0 = clamp(s_coords[2*COORD_W-1:COORD_W]);
    assign x1 = clamp(s_coords[3*COORD_W-1:2*COORD_W]);
    assign y1 = clamp(s_coords[4*COORD_W-1:3*COORD_W]);

    assign xpos    = (x1 > x0);
    assign ypos    = (y1 > y0);
    assign dxs     = (CW + 1)'(x1) - (CW + 1)'(x0);
    assign dys     = (CW + 1)'(y1) - (CW + 1)'(y0);
    assign ext_x_c = xpos ? EXT_W'(dxs) : EXT_W'(-dxs);
    assign ext_y_c = ypos ? EXT_W'(dys) : EXT_W'(-dys);
    // distance in fractions to the first cell line crossed
    assign mx_c    = xpos ? ONE - MUL_W'(x0[FRAC_BITS-1:0]) : MUL_W'(x0[FRAC_BITS-1:0]);
    assign my_c    = ypos ? ONE - MUL_W'(y0[FRAC_BITS-1:0]) : MUL_W'(y0[FRAC_BITS-1:0]);

    assign en       = !(v2_reg && q_full);
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (en) begin
            fx0_reg    <= CELL_W'(x0 >>> FRAC_BITS);
            fx1_reg    <= CELL_W'(x1 >>> FRAC_BITS);
            fy0_reg    <= CELL_W'(y0 >>> FRAC_BITS);
            fy1_reg    <= CELL_W'(y1 >>> FRAC_BITS);
            ext_x1_reg <= ext_x_c;
            ext_y1_reg <= ext_y_c;
            mx_reg     <= mx_c;
            my_reg     <= my_c;
            xneg1_reg  <= !xpos;
            yneg1_reg  <= !ypos;
        end
    end

    assign dcol = xneg1_reg ? WALK_W'(fx0_reg) - WALK_W'(fx1_reg)
                            : WALK_W'(fx1_reg) - WALK_W'(fx0_reg);
    assign drow = yneg1_reg ? WALK_W'(fy0_reg) - WALK_W'(fy1_reg)
                            : WALK_W'(fy1_reg) - WALK_W'(fy0_reg);
    assign cells_c = CNT_W'(1) + CNT_W'(dcol) + CNT_W'(drow);

    always_comb begin
        if (ext_y1_reg == '0) begin
            mode_c = MODE_HORIZ;
        end else if (ext_x1_reg == '0) begin
            mode_c = MODE_VERT;
        end else begin
            mode_c = MODE_GENERAL;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_x_reg <= PROD_W'(mx_reg) * PROD_W'(ext_y1_reg);
            prod_y_reg <= PROD_W'(my_reg) * PROD_W'(ext_x1_reg);
            col_reg    <= WALK_W'(fx0_reg);
            row_reg    <= WALK_W'(fy0_reg);
            cells_reg  <= cells_c;
            mode_reg   <= mode_c;
            ext_x2_reg <= ext_x1_reg;
            ext_y2_reg <= ext_y1_reg;
            xneg2_reg  <= xneg1_reg;
            yneg2_reg  <= yneg1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
        end
    end

    assign err_c  = ERR_W'(prod_x_reg) - ERR_W'(prod_y_reg);
    assign q_push = v2_reg && !q_full;
    assign q_data = {err_c, ext_y2_reg, ext_x2_reg, mode_reg, yneg2_reg, xneg2_reg,
                     cells_reg, row_reg, col_reg};

endmodule

// File: hw/rtl/gclw_back.sv
// ----------------------------------------------------------------------------
// gclw_back: cell walker
// Takes one walk command at a time and steps through the touched cells,
// one per cycle while the output is not stalled, into an output register.
// ----------------------------------------------------------------------------
module gclw_back #(
    parameter int FRAC_BITS = 8,
    parameter int CMD_W     = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [CMD_W-1:0]    q_data,
    input  logic                q_empty,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output gclw_pkg::cell_t     m_cell
);

    import gclw_pkg::*;

    localparam int EXT_W = FRAC_BITS + 5;
    localparam int ERR_W = 2 * FRAC_BITS + 8;

    logic                    walking_reg;
    logic [WALK_W-1:0]       col_reg, row_reg;
    logic signed [ERR_W-1:0] err_reg;
    logic [CNT_W-1:0]        cells_reg;
    logic                    xneg_reg, yneg_reg;
    logic [1:0]              mode_reg;
    logic [EXT_W-1:0]        ext_x_reg, ext_y_reg;
    logic                    out_valid_reg;
    cell_t                   out_cell_reg;

    logic [WALK_W-1:0]       q_col, q_row;
    logic [CNT_W-1:0]        q_cells;
    logic                    q_xneg, q_yneg;
    logic [1:0]              q_mode;
    logic [EXT_W-1:0]        q_ext_x, q_ext_y;
    logic signed [ERR_W-1:0] q_err;

    logic                    emit;
    logic                    step_row, step_col, step_diag;
    logic                    last;
    logic signed [ERR_W-1:0] ext_x_sh, ext_y_sh;
    logic [WALK_W-1:0]       col_inc, row_inc;

    assign {q_err, q_ext_y, q_ext_x, q_mode, q_yneg, q_xneg, q_cells, q_row, q_col} = q_data;

    assign emit = walking_reg && (!out_valid_reg || m_ready);

    assign step_row  = (mode_reg == MODE_VERT) ||
                       ((mode_reg == MODE_GENERAL) && (err_reg > 0));
    assign step_col  = !step_row && ((mode_reg == MODE_HORIZ) || (err_reg < 0));
    // exact tie: cross the corner, two cells counted
    assign step_diag = !step_row && !step_col;
    assign last      = (cells_reg <= CNT_W'(1)) || (step_diag && (cells_reg <= CNT_W'(2)));

    assign ext_x_sh = $signed(ERR_W'(ext_x_reg) << FRAC_BITS);
    assign ext_y_sh = $signed(ERR_W'(ext_y_reg) << FRAC_BITS);
    assign col_inc  = xneg_reg ? '1 : WALK_W'(1);
    assign row_inc  = yneg_reg ? '1 : WALK_W'(1);

    assign q_pop = !q_empty && (!walking_reg || (emit && last));

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            col_reg   <= q_col;
            row_reg   <= q_row;
            err_reg   <= q_err;
            cells_reg <= q_cells;
            xneg_reg  <= q_xneg;
            yneg_reg  <= q_yneg;
            mode_reg  <= q_mode;
            ext_x_reg <= q_ext_x;
            ext_y_reg <= q_ext_y;
        end else if (emit) begin
            if (step_row) begin
                row_reg   <= row_reg + row_inc;
                err_reg   <= err_reg - ext_x_sh;
                cells_reg <= cells_reg - CNT_W'(1);
            end else if (step_col) begin
                col_reg   <= col_reg + col_inc;
                err_reg   <= err_reg + ext_y_sh;
                cells_reg <= cells_reg - CNT_W'(1);
            end else begin
                col_reg   <= col_reg + col_inc;
                row_reg   <= row_reg + row_inc;
                err_reg   <= err_reg + ext_x_sh - ext_y_sh;
                cells_reg <= cells_reg - CNT_W'(2);
            end
        end
        if (emit) begin
            out_cell_reg.last <= last;
            out_cell_reg.row  <= row_reg[CELL_W-1:0];
            out_cell_reg.col  <= col_reg[CELL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            walking_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                walking_reg <= 1'b1;
            end else if (emit && last) begin
                walking_reg <= 1'b0;
            end
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_cell  = out_cell_reg;

endmodule

// File: hw/rtl/grid_cell_line_walker.sv
// ----------------------------------------------------------------------------
// grid_cell_line_walker: unit grid traversal of a line segment
// Emits every grid cell a segment touches, in order, with the last one marked.
// ----------------------------------------------------------------------------
// Path: both setup stages, the queue, the walker registers, the output register.
// Output: one cell per cycle while not stalled; a segment gives N cells,
//   N = 1 + |column span| + |row span| less one per corner crossing (1..63).
// Setup runs two stages ahead through a two-entry queue, so segments follow
//   each other with no gap while the output keeps draining.
// Reset: synchronous active-low aresetn empties the pipeline, queue and walker.
module grid_cell_line_walker #(
    parameter int GRID_CELLS = 32,
    parameter int FRAC_BITS  = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // x_start[12:0], y_start[25:13], x_end[38:26], y_end[51:39], zero pad
    input  logic [gclw_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // cell_col[4:0], cell_row[9:5], zero pad
    output logic [gclw_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tlast
);

    import gclw_pkg::*;

    localparam int EXT_W = FRAC_BITS + 5;
    localparam int ERR_W = 2 * FRAC_BITS + 8;
    localparam int CMD_W = 2 * WALK_W + CNT_W + 2 + 2 + 2 * EXT_W + ERR_W;

    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_empty;
    logic [CMD_W-1:0] q_wr_data;
    logic [CMD_W-1:0] q_rd_data;
    cell_t            walk_cell;

    gclw_front #(
        .GRID_CELLS (GRID_CELLS),
        .FRAC_BITS  (FRAC_BITS),
        .CMD_W      (CMD_W)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_coords (s_tdata[4*COORD_W-1:0]),
        .q_push   (q_push),
        .q_data   (q_wr_data),
        .q_full   (q_full)
    );

    gclw_fifo #(
        .WIDTH (CMD_W)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_data (q_wr_data),
        .full    (q_full),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    gclw_back #(
        .FRAC_BITS (FRAC_BITS),
        .CMD_W     (CMD_W)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_data  (q_rd_data),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_cell  (walk_cell)
    );

    assign m_tdata = {(M_TDATA_W - 2 * CELL_W)'(0), walk_cell.row, walk_cell.col};
    assign m_tlast = walk_cell.last;

endmodule

// File: hw/rtl/gclw_checker.sv
// ----------------------------------------------------------------------------
// gclw_checker: port-level checks for the grid cell line walker
// Tracks segments in flight, checks that every cell has one, and checks the output hold.
// ----------------------------------------------------------------------------
module gclw_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [gclw_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tlast
);

    logic [3:0] pending_reg;
    logic       in_xfer;
    logic       end_xfer;

    assign in_xfer  = s_tvalid && s_tready;
    assign end_xfer = m_tvalid && m_tready && m_tlast;

    // count segments taken in whose last cell has not gone out
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 4'd0;
        end else if (in_xfer && !end_xfer) begin
            pending_reg <= pending_reg + 4'd1;
        end else if (end_xfer && !in_xfer) begin
            pending_reg <= pending_reg - 4'd1;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    a_no_orphan: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pending_reg != 4'd0)
        else $error("cell emitted with no segment in flight");

    a_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg <= 4'd6)
        else $error("more segments in flight than the datapath holds");

endmodule

bind grid_cell_line_walker gclw_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// File: tb/sv/tb_grid_cell_line_walker.sv
// ----------------------------------------------------------------------------
// tb_grid_cell_line_walker: self-checking bench for the grid cell line walker
// Streams segments in and checks every emitted cell against a traversal
// predictor or a typed cell: a table of directed segments first, then biased
// random segments, with random idling on both sides, one long output hold-off and one drain.
// ----------------------------------------------------------------------------
module tb_grid_cell_line_walker;
    timeunit 1ns;
    timeprecision 1ps;

    import gclw_pkg::*;

    localparam int GRID_CELLS = 32;
    localparam int FRAC_BITS  = 8;
    localparam int MAX_CELLS  = 63;
    localparam int NUM_ITEMS  = 310;
    localparam int HOLD_OFF   = 300;   // cycles of the long output stall
    localparam int PAUSE_AT   = 100;   // item before which the input drains
    localparam int CALM_FROM  = 150;   // no idling on either side from here
    localparam int CALM_TO    = 260;
    localparam int STALL_AT   = 205;   // item that starts the long stall

    typedef struct {
        logic signed [COORD_W-1:0] xs;
        logic signed [COORD_W-1:0] ys;
        logic signed [COORD_W-1:0] xe;
        logic signed [COORD_W-1:0] ye;
    } seg_t;

    // typed rows are point segments whose single cell is known by sight
    typedef struct {
        int xs;
        int ys;
        int xe;
        int ye;
        bit typed;
        int cell_col;
        int cell_row;
    } seg_row_t;

    localparam int DIR_ROWS = 18;
    seg_row_t dir_tab [DIR_ROWS] = '{
        '{-4096, -4096, -4096, -4096, 1'b1, -16, -16},
        '{ 4095,  4095,  4095,  4095, 1'b1,  15,  15},
        '{    0,     0,     0,     0, 1'b1,   0,   0},
        '{   -1,    -1,    -1,    -1, 1'b1,  -1,  -1},
        '{  128, -4096,   128,  4095, 1'b0,   0,   0},  // vertical, upward
        '{ -128,  4095,  -128, -4096, 1'b0,   0,   0},  // vertical, downward
        '{-4096,   300,  4095,   300, 1'b0,   0,   0},  // horizontal, rightward
        '{ 4095,  -300, -4096,  -300, 1'b0,   0,   0},  // horizontal, leftward
        '{-4096, -4096,  4095,  4095, 1'b0,   0,   0},  // tie from the first step
        '{ 4095, -4096, -4096,  4095, 1'b0,   0,   0},  // anti-diagonal
        '{  128,   128,  1152,  1152, 1'b0,   0,   0},  // through corners
        '{-3840, -3000,  3900,  2500, 1'b0,   0,   0},
        '{  700, -4000,  -900,  3800, 1'b0,   0,   0},
        '{-4096, -4050,  4095,  4050, 1'b0,   0,   0},  // near the cell bound
        '{   10,    20,   200,   240, 1'b0,   0,   0},  // inside one cell
        '{  255,   255,   256,   256, 1'b0,   0,   0},  // tie on a corner
        '{ -300,   100, -1200, -2000, 1'b0,   0,   0},
        '{ 2048,  2048,  2049,  2048, 1'b0,   0,   0}
    };

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;

    cell_t cell_exp_q [$];
    int    fail_count;
    bit    hold_off_req;
    bit    calm_rx;

    grid_cell_line_walker #(
        .GRID_CELLS (GRID_CELLS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic longint clamp_raw(input longint v);
        longint lim;
        lim = longint'(GRID_CELLS / 2) << FRAC_BITS;
        if (v < -lim)
            return -lim;
        if (v > lim - 1)
            return lim - 1;
        return v;
    endfunction

    function automatic logic signed [COORD_W-1:0] sat_coord(input int v);
        if (v < -4096)
            return COORD_W'(-4096);
        if (v > 4095)
            return COORD_W'(4095);
        return COORD_W'(v);
    endfunction

    // Walk the segment cell by cell and queue every touched cell.
    function automatic void trace_segment_cells(input seg_t seg);
        longint one, x0, y0, x1, y1, ext_x, ext_y;
        longint col, row, left, err, ex, ey, cstep, rstep;
        logic [1:0] mode;
        int n;
        cell_t c;
        one = longint'(1) << FRAC_BITS;
        x0 = clamp_raw(longint'(seg.xs));
        y0 = clamp_raw(longint'(seg.ys));
        x1 = clamp_raw(longint'(seg.xe));
        y1 = clamp_raw(longint'(seg.ye));
        ext_x = (x1 > x0) ? x1 - x0 : x0 - x1;
        ext_y = (y1 > y0) ? y1 - y0 : y0 - y1;
        col = x0 >>> FRAC_BITS;
        row = y0 >>> FRAC_BITS;
        left = 1;
        cstep = 0;
        rstep = 0;
        ex = 0;
        ey = 0;
        n = 0;
        if (ext_x != 0) begin
            if (x1 > x0) begin
                cstep = 1;
                left += (x1 >>> FRAC_BITS) - col;
                ex = (one - (x0 & (one - 1))) * ext_y;
            end else begin
                cstep = -1;
                left += col - (x1 >>> FRAC_BITS);
                ex = (x0 & (one - 1)) * ext_y;
            end
        end
        if (ext_y != 0) begin
            if (y1 > y0) begin
                rstep = 1;
                left += (y1 >>> FRAC_BITS) - row;
                ey = (one - (y0 & (one - 1))) * ext_x;
            end else begin
                rstep = -1;
                left += row - (y1 >>> FRAC_BITS);
                ey = (y0 & (one - 1)) * ext_x;
            end
        end
        err = ex - ey;
        if (ext_y == 0)
            mode = MODE_HORIZ;
        else if (ext_x == 0)
            mode = MODE_VERT;
        else
            mode = MODE_GENERAL;

        while (left > 0 && n < MAX_CELLS) begin
            c.col = col[CELL_W-1:0];
            c.row = row[CELL_W-1:0];
            n++;
            if (mode == MODE_VERT || (mode == MODE_GENERAL && err > 0)) begin
                row += rstep;
                if (mode == MODE_GENERAL)
                    err -= ext_x * one;
            end else if (mode == MODE_HORIZ || err < 0) begin
                col += cstep;
                if (mode == MODE_GENERAL)
                    err += ext_y * one;
            end else begin
                // exact tie: cross the corner, skipping one count
                col += cstep;
                row += rstep;
                err += (ext_x - ext_y) * one;
                left--;
            end
            left--;
            c.last = (left <= 0 || n >= MAX_CELLS);
            cell_exp_q.insert(cell_exp_q.size(), c);
        end
    endfunction

    function automatic seg_t random_segment();
        seg_t seg;
        int kind, dx, dy;
        kind = int'($urandom_range(99));
        seg.xs = COORD_W'($urandom);
        seg.ys = COORD_W'($urandom);
        seg.xe = COORD_W'($urandom);
        seg.ye = COORD_W'($urandom);
        if (kind < 15) begin
            // axis aligned, either way
            if ($urandom_range(1))
                seg.xe = seg.xs;
            else
                seg.ye = seg.ys;
        end else if (kind < 30) begin
            // equal extents and fractions, so the error term ties when both steps agree in sign and no end saturates
            seg.ys = {seg.ys[COORD_W-1:FRAC_BITS], seg.xs[FRAC_BITS-1:0]};
            dx = int'($urandom_range(3000));
            dy = $urandom_range(1) ? dx : -dx;
            dx = $urandom_range(1) ? dx : -dx;
            seg.xe = sat_coord(int'(seg.xs) + dx);
            seg.ye = sat_coord(int'(seg.ys) + dy);
        end else if (kind < 50) begin
            // short hop near the start point
            seg.xe = sat_coord(int'(seg.xs) + int'($urandom_range(600)) - 300);
            seg.ye = sat_coord(int'(seg.ys) + int'($urandom_range(600)) - 300);
        end
        return seg;
    endfunction

    task automatic drive_segment(input seg_t seg, input bit calm);
        while (!calm && $urandom_range(99) < 32) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - 4 * COORD_W){1'b0}}, seg.ye, seg.xe, seg.ys, seg.xs};
        do
            @(posedge aclk);
        while (!s_tready);
    endtask

    // input side
    initial begin : seg_source
        seg_t seg;
        cell_t c;
        bit calm;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        aresetn      = 1'b0;
        hold_off_req = 1'b0;
        calm_rx      = 1'b0;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        for (int i = 0; i < NUM_ITEMS; i++) begin
            if (i == PAUSE_AT) begin
                // let everything drain before going on
                @(negedge aclk);
                s_tvalid <= 1'b0;
                while (cell_exp_q.size() != 0)
                    @(posedge aclk);
            end
            calm    = (i >= CALM_FROM && i < CALM_TO);
            calm_rx = (i >= CALM_FROM && i < STALL_AT);
            if (i == STALL_AT)
                hold_off_req = 1'b1;

            if (i < DIR_ROWS) begin
                seg.xs = COORD_W'(dir_tab[i].xs);
                seg.ys = COORD_W'(dir_tab[i].ys);
                seg.xe = COORD_W'(dir_tab[i].xe);
                seg.ye = COORD_W'(dir_tab[i].ye);
            end else begin
                seg = random_segment();
            end

            drive_segment(seg, calm);

            if (i < DIR_ROWS && dir_tab[i].typed) begin
                c.col  = CELL_W'(dir_tab[i].cell_col);
                c.row  = CELL_W'(dir_tab[i].cell_row);
                c.last = 1'b1;
                cell_exp_q.insert(cell_exp_q.size(), c);
            end else begin
                trace_segment_cells(seg);
            end
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (cell_exp_q.size() != 0)
            @(posedge aclk);
        repeat (16) @(posedge aclk);

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // output side: random backpressure, plus one long hold-off on request
    initial begin : cell_sink
        int hold_left;
        m_tready  = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_OFF - 1;
                m_tready    <= 1'b0;
            end else begin
                m_tready <= calm_rx ? 1'b1 : ($urandom_range(99) >= 32);
            end
        end
    end

    // check each cell transfer against the oldest expected cell
    initial begin : cell_check
        cell_t want;
        fail_count = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (cell_exp_q.size() == 0) begin
                    $error("unexpected cell transfer: col %0d row %0d last %0b",
                           $signed(m_tdata[4:0]), $signed(m_tdata[9:5]), m_tlast);
                    fail_count++;
                end else begin
                    want = cell_exp_q.pop_front();
                    if (m_tdata[4:0] !== want.col) begin
                        $error("cell_col: expected %0d, got %0d",
                               want.col, $signed(m_tdata[4:0]));
                        fail_count++;
                    end
                    if (m_tdata[9:5] !== want.row) begin
                        $error("cell_row: expected %0d, got %0d",
                               want.row, $signed(m_tdata[9:5]));
                        fail_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last_cell: expected %0b, got %0b", want.last, m_tlast);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial begin : watchdog
        #8_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: grid_cell_line_walker.f
hw/rtl/gclw_pkg.sv
hw/rtl/gclw_fifo.sv
hw/rtl/gclw_front.sv
hw/rtl/gclw_back.sv
hw/rtl/grid_cell_line_walker.sv
hw/rtl/gclw_checker.sv
tb/sv/tb_grid_cell_line_walker.sv
